@@ sv/assert_macros.svh @@
// assertion helpers for the command line parser
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

`define ASSERT_PROP(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("assertion failed");

`define ASSERT_NEVER(label, clk, rst_n, expr) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
		else $error("forbidden condition seen");

`else

`define ASSERT_PROP(label, clk, rst_n, prop)

`define ASSERT_NEVER(label, clk, rst_n, expr)

`endif

`endif

@@ sv/slcp_pkg.sv @@
`default_nettype none

package slcp_pkg;

	localparam logic [7:0] CHAR_CR = 8'h0d;
	localparam logic [7:0] CHAR_LF = 8'h0a;
	localparam logic [7:0] CHAR_S  = 8'h53;
	localparam logic [7:0] CHAR_O  = 8'h4f;
	localparam logic [7:0] CHAR_C  = 8'h43;
	localparam logic [7:0] CHAR_V  = 8'h56;
	localparam logic [7:0] CHAR_N  = 8'h4e;
	localparam logic [7:0] CHAR_F  = 8'h46;
	localparam logic [7:0] CHAR_LT = 8'h74;
	localparam logic [7:0] CHAR_0  = 8'h30;
	localparam logic [7:0] CHAR_8  = 8'h38;
	localparam logic [7:0] CHAR_9  = 8'h39;
	localparam logic [7:0] CHAR_UA = 8'h41;
	localparam logic [7:0] CHAR_UF = 8'h46;
	localparam logic [7:0] CHAR_LA = 8'h61;
	localparam logic [7:0] CHAR_LF_HEX = 8'h66;

	localparam logic [2:0] KIND_OK      = 3'd0;
	localparam logic [2:0] KIND_ERROR   = 3'd1;
	localparam logic [2:0] KIND_VERSION = 3'd2;
	localparam logic [2:0] KIND_SERIAL  = 3'd3;
	localparam logic [2:0] KIND_STATUS  = 3'd4;
	localparam logic [2:0] KIND_FRAME   = 3'd5;

	// header is 't', three id digits, one length digit
	localparam int HDR_LEN   = 5;
	localparam int MAX_T_LEN = 21;
	localparam logic [3:0] MAX_DLC = 4'd8;

	typedef struct packed {
		logic [2:0]       kind;
		logic [10:0]      can_id;
		logic [3:0]       data_len;
		logic [7:0][7:0]  data;
	} slcp_res_t;

	// {valid, value} of one hex digit, either case
	function automatic logic [4:0] hex_nib(input logic [7:0] ch);
		logic [7:0] d;
		begin
			d = 8'd0;
			if (ch >= CHAR_0 && ch <= CHAR_9) begin
				d = ch - CHAR_0;
				hex_nib = {1'b1, d[3:0]};
			end else if (ch >= CHAR_LA && ch <= CHAR_LF_HEX) begin
				d = ch - CHAR_LA + 8'd10;
				hex_nib = {1'b1, d[3:0]};
			end else if (ch >= CHAR_UA && ch <= CHAR_UF) begin
				d = ch - CHAR_UA + 8'd10;
				hex_nib = {1'b1, d[3:0]};
			end else begin
				hex_nib = 5'd0;
			end
		end
	endfunction

endpackage

`default_nettype wire

@@ sv/slcp_ram.sv @@
`default_nettype none

module slcp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32,
	localparam int AW = $clog2(DEPTH)
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

@@ sv/slcp_parser.sv @@
`default_nettype none

module slcp_parser import slcp_pkg::*; #(
	parameter int LINE_MAX = 32,
	localparam int AW = $clog2(LINE_MAX),
	localparam int CW = $clog2(LINE_MAX + 1)
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	input  wire logic          start_ovf,
	input  wire logic [CW-1:0] start_count,
	output logic               busy,
	output logic      [AW-1:0] rd_addr,
	input  wire logic [7:0]    rd_data,
	output logic               res_valid,
	input  wire logic          res_ready,
	output slcp_res_t          res
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_WALK = 2'd1;
	localparam logic [1:0] ST_DONE = 2'd2;

	logic [1:0]      state_q;
	logic            dv_q;
	logic            open_q;
	logic [CW-1:0]   cnt_q;
	logic [CW-1:0]   rd_q;
	logic [AW-1:0]   pos_q;
	logic            is_t_q;
	logic [11:0]     id_q;
	logic [3:0]      len_q;
	logic [3:0]      hi_q;
	logic [7:0][7:0] bytes_q;
	logic [2:0]      kind_q;

	logic [4:0]    hn;
	logic [7:0]    dig;
	logic          dig_ok;
	logic [4:0]    frame_len;
	logic [AW-1:0] off;
	logic          last;
	logic          more;

	logic       fin;
	logic [2:0] fin_kind;
	logic       set_t;
	logic       set_open;
	logic       clr_open;
	logic       id_shift;
	logic       len_ld;
	logic       hi_ld;
	logic       byte_ld;

	assign hn        = hex_nib(rd_data);
	assign dig       = rd_data - CHAR_0;
	assign dig_ok    = (rd_data >= CHAR_0) && (rd_data <= CHAR_8);
	assign frame_len = 5'(HDR_LEN) + {dig[3:0], 1'b0};
	assign off       = pos_q - AW'(HDR_LEN);
	assign last      = (CW'(pos_q) + CW'(1)) == cnt_q;
	assign more      = rd_q < cnt_q;
	assign rd_addr   = rd_q[AW-1:0];

	// decision for the stored character that the read port returns this cycle
	always_comb begin
		fin      = 1'b0;
		fin_kind = KIND_ERROR;
		set_t    = 1'b0;
		set_open = 1'b0;
		clr_open = 1'b0;
		id_shift = 1'b0;
		len_ld   = 1'b0;
		hi_ld    = 1'b0;
		byte_ld  = 1'b0;
		if (pos_q == '0) begin
			unique case (rd_data)
				CHAR_S: begin
					if (cnt_q != CW'(2)) begin
						fin = 1'b1;
					end
				end
				CHAR_O: begin
					fin = 1'b1;
					if (cnt_q == CW'(1)) begin
						fin_kind = KIND_OK;
						set_open = 1'b1;
					end
				end
				CHAR_C: begin
					fin = 1'b1;
					if (cnt_q == CW'(1)) begin
						fin_kind = KIND_OK;
						clr_open = 1'b1;
					end
				end
				CHAR_V: begin
					fin = 1'b1;
					if (cnt_q == CW'(1)) fin_kind = KIND_VERSION;
				end
				CHAR_N: begin
					fin = 1'b1;
					if (cnt_q == CW'(1)) fin_kind = KIND_SERIAL;
				end
				CHAR_F: begin
					fin = 1'b1;
					if (cnt_q == CW'(1)) fin_kind = KIND_STATUS;
				end
				CHAR_LT: begin
					if (open_q && cnt_q >= CW'(HDR_LEN) && cnt_q <= CW'(MAX_T_LEN)) begin
						set_t = 1'b1;
					end else begin
						fin = 1'b1;
					end
				end
				default: begin
					fin = 1'b1;
				end
			endcase
		end else if (!is_t_q) begin
			// speed digit of the S command
			fin = 1'b1;
			if (dig_ok) fin_kind = KIND_OK;
		end else if (pos_q < AW'(HDR_LEN - 1)) begin
			if (hn[4]) begin
				id_shift = 1'b1;
			end else begin
				fin = 1'b1;
			end
		end else if (pos_q == AW'(HDR_LEN - 1)) begin
			if (!id_q[11] && dig_ok && CW'(frame_len) == cnt_q) begin
				len_ld = 1'b1;
				if (dig[3:0] == 4'd0) begin
					fin      = 1'b1;
					fin_kind = KIND_FRAME;
				end
			end else begin
				fin = 1'b1;
			end
		end else begin
			if (!hn[4]) begin
				fin = 1'b1;
			end else if (!off[0]) begin
				hi_ld = 1'b1;
			end else begin
				byte_ld = 1'b1;
				if (last) begin
					fin      = 1'b1;
					fin_kind = KIND_FRAME;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			dv_q    <= 1'b0;
			open_q  <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					dv_q <= 1'b0;
					if (start) begin
						state_q <= start_ovf ? ST_DONE : ST_WALK;
					end
				end
				ST_WALK: begin
					dv_q <= more;
					if (dv_q) begin
						if (set_open) open_q <= 1'b1;
						if (clr_open) open_q <= 1'b0;
						if (fin) state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					dv_q <= 1'b0;
					if (res_ready) state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && start) begin
			cnt_q   <= start_count;
			rd_q    <= '0;
			is_t_q  <= 1'b0;
			id_q    <= '0;
			len_q   <= '0;
			bytes_q <= '0;
			kind_q  <= KIND_ERROR;
		end else if (state_q == ST_WALK) begin
			if (more) rd_q <= rd_q + CW'(1);
			pos_q <= rd_q[AW-1:0];
			if (dv_q) begin
				if (set_t) is_t_q <= 1'b1;
				if (id_shift) id_q <= {id_q[7:0], hn[3:0]};
				if (len_ld) len_q <= dig[3:0];
				if (hi_ld) hi_q <= hn[3:0];
				if (byte_ld) bytes_q[off[3:1]] <= {hi_q, hn[3:0]};
				if (fin) kind_q <= fin_kind;
			end
		end
	end

	assign busy      = state_q != ST_IDLE;
	assign res_valid = state_q == ST_DONE;

	always_comb begin
		res      = '0;
		res.kind = kind_q;
		if (kind_q == KIND_FRAME) begin
			res.can_id   = id_q[10:0];
			res.data_len = len_q;
			res.data     = bytes_q;
		end
	end

endmodule

`default_nettype wire

@@ sv/slcan_command_line_parser_top.sv @@
// a character that is not CR or LF is taken and written to the line store while there is room, else it marks overflow
// a line end starts a walk over the store, one stored character per cycle through the
// store's single read port; no input is taken until the result has been accepted
// an empty line gives no result; an overflowed line gives an error result without a walk
// reset (arst_n low) clears the count, overflow flag and handshakes and closes the channel;
// store contents stay undefined until written
`default_nettype none

`include "assert_macros.svh"

module slcan_command_line_parser_top import slcp_pkg::*; #(
	parameter int LINE_MAX = 32
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [7:0]  char_in,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic      [2:0]  kind,
	output logic      [10:0] can_id,
	output logic      [3:0]  data_len,
	output logic      [7:0]  byte0,
	output logic      [7:0]  byte1,
	output logic      [7:0]  byte2,
	output logic      [7:0]  byte3,
	output logic      [7:0]  byte4,
	output logic      [7:0]  byte5,
	output logic      [7:0]  byte6,
	output logic      [7:0]  byte7
);

	localparam int AW = $clog2(LINE_MAX);
	localparam int CW = $clog2(LINE_MAX + 1);

	logic [CW-1:0] count_q;
	logic          ovf_q;
	logic          out_valid_q;
	slcp_res_t     out_q;

	logic          in_xfer;
	logic          term;
	logic          room;
	logic          wr_en;
	logic          p_start;
	logic          p_busy;
	logic [AW-1:0] rd_addr;
	logic [7:0]    rd_data;
	logic          res_valid;
	logic          res_ready;
	slcp_res_t     res;

	assign in_ready = !p_busy;
	assign in_xfer  = in_valid && in_ready;
	assign term     = (char_in == CHAR_CR) || (char_in == CHAR_LF);
	assign room     = count_q < CW'(LINE_MAX);
	assign wr_en    = in_xfer && !term && room;
	assign p_start  = in_xfer && term && (ovf_q || count_q != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			ovf_q   <= 1'b0;
		end else if (in_xfer) begin
			if (term) begin
				count_q <= '0;
				ovf_q   <= 1'b0;
			end else if (room) begin
				count_q <= count_q + CW'(1);
			end else begin
				ovf_q <= 1'b1;
			end
		end
	end

	slcp_ram #(
		.WIDTH(8),
		.DEPTH(LINE_MAX)
	) u_line_store (
		.clk  (clk),
		.we   (wr_en),
		.waddr(count_q[AW-1:0]),
		.wdata(char_in),
		.raddr(rd_addr),
		.rdata(rd_data)
	);

	slcp_parser #(
		.LINE_MAX(LINE_MAX)
	) u_parser (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (p_start),
		.start_ovf  (ovf_q),
		.start_count(count_q),
		.busy       (p_busy),
		.rd_addr    (rd_addr),
		.rd_data    (rd_data),
		.res_valid  (res_valid),
		.res_ready  (res_ready),
		.res        (res)
	);

	// output register frees when empty or when its transaction completes
	assign res_ready = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_ready) begin
			out_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_ready && res_valid) begin
			out_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign kind      = out_q.kind;
	assign can_id    = out_q.can_id;
	assign data_len  = out_q.data_len;
	assign byte0     = out_q.data[0];
	assign byte1     = out_q.data[1];
	assign byte2     = out_q.data[2];
	assign byte3     = out_q.data[3];
	assign byte4     = out_q.data[4];
	assign byte5     = out_q.data[5];
	assign byte6     = out_q.data[6];
	assign byte7     = out_q.data[7];

	`ASSERT_NEVER(a_count_in_range, clk, arst_n, count_q > CW'(LINE_MAX))
	`ASSERT_PROP(a_ovf_only_when_full, clk, arst_n, ovf_q |-> (count_q == CW'(LINE_MAX)))
	`ASSERT_PROP(a_frame_len_ok, clk, arst_n, (out_valid_q && out_q.kind == KIND_FRAME) |-> (out_q.data_len <= MAX_DLC))
	`ASSERT_PROP(a_plain_reply_zero, clk, arst_n, (out_valid_q && out_q.kind != KIND_FRAME) |-> (out_q.can_id == '0 && out_q.data_len == '0 && out_q.data == '0))

endmodule

`default_nettype wire
